>>> rtl/assert_macros.svh
// Assertion helper macros for the UTF-16LE to UTF-8 transcoder.
// No dependencies; each user needs signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked property that must hold during reset as well.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> rtl/u16u8_pkg.sv
// Shared types and constants of the UTF-16LE to UTF-8 transcoder.
// No dependencies.
package u16u8_pkg;

   localparam int CU_W  = 16;
   localparam int CP_W  = 21;
   localparam int CNT_W = 18;
   localparam int NB_W  = 3;

   localparam logic [5:0]       SURR_HIGH_TAG = 6'b110110;
   localparam logic [5:0]       SURR_LOW_TAG  = 6'b110111;
   localparam logic [CP_W-1:0]  SUPP_BASE     = 21'h10000;
   localparam logic [CP_W-1:0]  LIM_1B        = 21'h00080;
   localparam logic [CP_W-1:0]  LIM_2B        = 21'h00800;
   localparam logic [CP_W-1:0]  LIM_3B        = 21'h10000;
   localparam logic [CNT_W-1:0] COUNT_MAX     = 18'h3ffff;

   // One decoded unit of work: its code point bytes, then a terminator or error.
   typedef struct packed {
      logic [CP_W-1:0]  cp;
      logic [NB_W-1:0]  nbytes;
      logic [NB_W-1:0]  nres;
      logic             err;
      logic             term;
      logic [CNT_W-1:0] count;
   } job_type;

endpackage

>>> rtl/u16u8_req_if.sv
// Input channel: one UTF-16 code unit per transfer.
// Depends on u16u8_pkg.
interface u16u8_req_if;
   import u16u8_pkg::*;

   logic            valid;
   logic            ready;
   logic [CU_W-1:0] code_unit;
   logic            last_unit;

   modport source (output valid, output code_unit, output last_unit, input ready);
   modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

>>> rtl/u16u8_rsp_if.sv
// Result channel: one UTF-8 byte, terminator or error per transfer.
// Depends on u16u8_pkg.
interface u16u8_rsp_if;
   import u16u8_pkg::*;

   logic             valid;
   logic             ready;
   logic [7:0]       out_byte;
   logic             last_of_run;
   logic             end_of_string;
   logic             error;
   logic [CNT_W-1:0] byte_count;

   modport source (output valid, output out_byte, output last_of_run,
                   output end_of_string, output error, output byte_count, input ready);
   modport sink   (input valid, input out_byte, input last_of_run,
                   input end_of_string, input error, input byte_count, output ready);
endinterface

>>> rtl/u16u8_front.sv
// Front end: accepts code units, pairs surrogates, tracks string state and
// byte count, and pushes one job per unit that yields results. Uses u16u8_pkg.
`include "assert_macros.svh"
module u16u8_front (
   input  logic               clock,
   input  logic               reset,
   u16u8_req_if.sink          req_ch,
   input  logic               q_full,
   output logic               q_push,
   output u16u8_pkg::job_type q_job
);
   import u16u8_pkg::*;

   logic [9:0]       pending_high_ff, pending_high_in;
   logic             pending_valid_ff, pending_valid_in;
   logic             error_seen_ff, error_seen_in;
   logic [CNT_W-1:0] bytes_ff, bytes_in;

   logic             accept;
   logic             is_high, is_low;
   logic             enc;
   logic [CP_W-1:0]  cp;
   logic [NB_W-1:0]  nbytes;
   logic [CNT_W:0]   sum_bytes, sum_total;
   logic [CNT_W-1:0] new_bytes, total;
   logic [9:0]       ph_n;
   logic             pv_n, err_n;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_high      = req_ch.code_unit[15:10] == SURR_HIGH_TAG;
   assign is_low       = req_ch.code_unit[15:10] == SURR_LOW_TAG;

   always_comb begin
      err_n = error_seen_ff;
      pv_n  = pending_valid_ff;
      ph_n  = pending_high_ff;
      enc   = 1'b0;
      cp    = CP_W'(req_ch.code_unit);
      if (!error_seen_ff) begin
         if (pending_valid_ff) begin
            pv_n = 1'b0;
            ph_n = '0;
            if (is_low) begin
               enc = 1'b1;
               cp  = {1'b0, pending_high_ff, req_ch.code_unit[9:0]} + SUPP_BASE;
            end else begin
               err_n = 1'b1;
            end
         end else if (is_high) begin
            if (req_ch.last_unit) begin
               err_n = 1'b1;
            end else begin
               ph_n = req_ch.code_unit[9:0];
               pv_n = 1'b1;
            end
         end else if (is_low) begin
            err_n = 1'b1;
         end else begin
            enc = 1'b1;
         end
      end
   end

   always_comb begin
      if (!enc) begin
         nbytes = NB_W'(0);
      end else if (cp < LIM_1B) begin
         nbytes = NB_W'(1);
      end else if (cp < LIM_2B) begin
         nbytes = NB_W'(2);
      end else if (cp < LIM_3B) begin
         nbytes = NB_W'(3);
      end else begin
         nbytes = NB_W'(4);
      end
   end

   assign sum_bytes = {1'b0, bytes_ff} + (CNT_W+1)'(nbytes);
   assign sum_total = sum_bytes + (CNT_W+1)'(1);
   assign new_bytes = sum_bytes[CNT_W] ? COUNT_MAX : sum_bytes[CNT_W-1:0];
   assign total     = sum_total[CNT_W] ? COUNT_MAX : sum_total[CNT_W-1:0];

   always_comb begin
      q_job.cp     = cp;
      q_job.nbytes = nbytes;
      q_job.count  = total;
      if (req_ch.last_unit) begin
         q_job.err  = err_n;
         q_job.term = !err_n;
         q_job.nres = err_n ? NB_W'(1) : nbytes + NB_W'(1);
      end else begin
         q_job.err  = 1'b0;
         q_job.term = 1'b0;
         q_job.nres = nbytes;
      end
      pending_high_in  = pending_high_ff;
      pending_valid_in = pending_valid_ff;
      error_seen_in    = error_seen_ff;
      bytes_in         = bytes_ff;
      if (accept) begin
         if (req_ch.last_unit) begin
            pending_high_in  = '0;
            pending_valid_in = 1'b0;
            error_seen_in    = 1'b0;
            bytes_in         = '0;
         end else begin
            pending_high_in  = ph_n;
            pending_valid_in = pv_n;
            error_seen_in    = err_n;
            bytes_in         = new_bytes;
         end
      end
   end

   assign q_push = accept && (q_job.nres != NB_W'(0));

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_high_ff  <= '0;
         pending_valid_ff <= 1'b0;
         error_seen_ff    <= 1'b0;
         bytes_ff         <= '0;
      end else begin
         pending_high_ff  <= pending_high_in;
         pending_valid_ff <= pending_valid_in;
         error_seen_ff    <= error_seen_in;
         bytes_ff         <= bytes_in;
      end
   end

   `ASSERT_CLK(a_pend_err_excl, !(pending_valid_ff && error_seen_ff), "pending and error both set")
   `ASSERT_CLK(a_err_single, (q_push && q_job.err) |-> (q_job.nres == NB_W'(1) && !q_job.term), "error job not single")
endmodule

>>> rtl/u16u8_queue.sv
// Short job queue between front and back end, built from registers.
// Uses u16u8_pkg.
`include "assert_macros.svh"
module u16u8_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u16u8_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output u16u8_pkg::job_type head_job
);
   import u16u8_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_QW = $clog2(DEPTH + 1);

   job_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]   count_ff, count_in;

   assign full     = count_ff == CNT_QW'(DEPTH);
   assign empty    = count_ff == CNT_QW'(0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   `ASSERT_CLK(a_no_overflow, push |-> !full, "push into full queue")
   `ASSERT_CLK(a_no_underflow, pop |-> !empty, "pop from empty queue")
endmodule

>>> rtl/u16u8_back.sv
// Back end: takes jobs from the queue and emits their results, one per cycle
// while jobs wait and rsp_ch is ready, through a registered output stage. Uses u16u8_pkg.
`include "assert_macros.svh"
module u16u8_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  u16u8_pkg::job_type q_head,
   output logic               q_pop,
   u16u8_rsp_if.source        rsp_ch
);
   import u16u8_pkg::*;

   function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                            input logic [NB_W-1:0] nb,
                                            input logic [NB_W-1:0] k);
      logic [7:0] b;
      b = 8'h00;
      case (nb)
         NB_W'(1): b = cp[7:0];
         NB_W'(2): b = (k == NB_W'(0)) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         NB_W'(3): begin
            case (k)
               NB_W'(0): b = {4'b1110, cp[15:12]};
               NB_W'(1): b = {2'b10, cp[11:6]};
               default:  b = {2'b10, cp[5:0]};
            endcase
         end
         NB_W'(4): begin
            case (k)
               NB_W'(0): b = {5'b11110, cp[20:18]};
               NB_W'(1): b = {2'b10, cp[17:12]};
               NB_W'(2): b = {2'b10, cp[11:6]};
               default:  b = {2'b10, cp[5:0]};
            endcase
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   job_type          job_ff;
   logic             work_valid_ff;
   logic [NB_W-1:0]  idx_ff;
   logic             out_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff, out_eos_ff, out_err_ff;
   logic [CNT_W-1:0] out_count_ff;

   logic             load_out, work_last, is_byte;

   assign load_out  = work_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign work_last = idx_ff == (job_ff.nres - NB_W'(1));
   assign q_pop     = !q_empty && (!work_valid_ff || (load_out && work_last));
   assign is_byte   = !job_ff.err && (idx_ff < job_ff.nbytes);

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.out_byte      = out_byte_ff;
   assign rsp_ch.last_of_run   = out_last_ff;
   assign rsp_ch.end_of_string = out_eos_ff;
   assign rsp_ch.error         = out_err_ff;
   assign rsp_ch.byte_count    = out_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         idx_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (q_pop) begin
            work_valid_ff <= 1'b1;
            idx_ff        <= '0;
         end else if (load_out) begin
            idx_ff <= idx_ff + NB_W'(1);
            if (work_last) begin
               work_valid_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_head;
      end
      if (load_out) begin
         out_byte_ff  <= is_byte ? utf8_byte(job_ff.cp, job_ff.nbytes, idx_ff) : 8'h00;
         out_last_ff  <= work_last;
         out_eos_ff   <= !is_byte;
         out_err_ff   <= job_ff.err;
         out_count_ff <= (!is_byte && job_ff.term) ? job_ff.count : '0;
      end
   end

   `ASSERT_CLK(a_idx_bound, work_valid_ff |-> (idx_ff < job_ff.nres), "result index past job")
endmodule

>>> rtl/utf16le_to_utf8_transcoder.sv
// UTF-16LE to UTF-8 transcoder, top level.
// Depends on u16u8_pkg, u16u8_req_if, u16u8_rsp_if, u16u8_front, u16u8_queue,
// u16u8_back.
//
// Usage: req_ch carries one UTF-16 code unit per transfer, last_unit marking
// the final unit of a string. rsp_ch carries one result per transfer: a UTF-8
// byte, or at string end a zero terminator with byte_count (terminator
// included), or a single error result if the string held a bad surrogate
// sequence. last_of_run flags the final result caused by one code unit.
// A high surrogate that is not the last unit gives no result; its bytes come with the following unit.
// The first result of a unit passes the job queue, the back end's job register
// and the output register. Throughput: one result per cycle at the output
// register while rsp_ch is ready; a unit yields 0 to 5 results (1-4 bytes
// plus terminator); a new unit is taken every cycle the QUEUE_DEPTH-entry queue has room.
// Reset (synchronous, active high) drops any partial string, queued jobs and
// the pending result. When rsp_ch stalls the output register holds its
// result, the back end waits, and req_ch.ready falls once the queue is full.
module utf16le_to_utf8_transcoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   u16u8_req_if.sink   req_ch,
   u16u8_rsp_if.source rsp_ch
);
   import u16u8_pkg::*;

   logic    q_push, q_full, q_pop, q_empty;
   job_type push_job, head_job;

   u16u8_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (push_job)
   );

   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (head_job)
   );

   u16u8_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (head_job),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );
endmodule
